[hdl/cc_cv_charge_controller_macros.svh]
// Assertion macros for the CC/CV charge controller
// Used by the modules that carry concurrent checks; relies on clk_i and rst_ni in scope
`ifndef CC_CV_CHARGE_CONTROLLER_MACROS_SVH
`define CC_CV_CHARGE_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// condition that must hold at every clock edge out of reset
`define CCV_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("check failed");
// same-cycle implication
`define CCV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define CCV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CCV_ASSERT(lbl, expr)
`define CCV_ASSERT_IMPL(lbl, ante, cons)
`define CCV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/ccv_pkg.sv]
// Shared types and constants for the CC/CV charge controller
// No dependencies
package ccv_pkg;

  localparam int unsigned RegW   = 13;
  localparam int unsigned MeasW  = 16;
  localparam int unsigned DriveW = 16;
  localparam int unsigned CfgAddrW = 3;

  // register indexes of the configuration port
  localparam logic [CfgAddrW-1:0] CFG_TARGET_VOLTAGE = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_TARGET_CURRENT = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_CUTOFF_CURRENT = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_MIN_VOLTAGE    = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_MAX_VOLTAGE    = 3'd4;

  // register reset values
  localparam logic [RegW-1:0] RST_TARGET_VOLTAGE = 13'd4200;
  localparam logic [RegW-1:0] RST_TARGET_CURRENT = 13'd1000;
  localparam logic [RegW-1:0] RST_CUTOFF_CURRENT = 13'd50;
  localparam logic [RegW-1:0] RST_MIN_VOLTAGE    = 13'd1000;
  localparam logic [RegW-1:0] RST_MAX_VOLTAGE    = 13'd4350;

  // regulation constants
  localparam logic [DriveW-1:0] DRIVE_MAX      = 16'hFFFF;
  localparam logic [DriveW-1:0] CV_COARSE_STEP = 16'd10;
  localparam logic [MeasW:0]    CV_FINE_BAND   = 17'd5;
  localparam logic [MeasW:0]    SUCCESS_MARGIN = 17'd3;
  localparam logic [MeasW-1:0]  MIN_CURRENT    = 16'd10;

  // command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_CC      = 3'd1,
    ST_CV      = 3'd2,
    ST_SUCCESS = 3'd3,
    ST_VFAULT  = 3'd4,
    ST_NOCUR   = 3'd5
  } status_e;

  typedef struct packed {
    logic [RegW-1:0] volt_setpoint;
    logic [RegW-1:0] curr_setpoint;
    logic [RegW-1:0] cutoff_current;
    logic [RegW-1:0] min_voltage;
    logic [RegW-1:0] max_voltage;
  } cfg_t;

  typedef struct packed {
    logic [DriveW-1:0] drive;
    logic              running;
    status_e           outcome;
  } chg_state_t;

endpackage

[hdl/ccv_cfg_regs.sv]
// Configuration register file of the CC/CV charge controller
// Depends on ccv_pkg
module ccv_cfg_regs import ccv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [RegW-1:0]     cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode of the register index, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_TARGET_VOLTAGE: cfg_d.volt_setpoint  = cfg_wdata_i;
        CFG_TARGET_CURRENT: cfg_d.curr_setpoint  = cfg_wdata_i;
        CFG_CUTOFF_CURRENT: cfg_d.cutoff_current = cfg_wdata_i;
        CFG_MIN_VOLTAGE:    cfg_d.min_voltage    = cfg_wdata_i;
        CFG_MAX_VOLTAGE:    cfg_d.max_voltage    = cfg_wdata_i;
        default:            cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volt_setpoint  <= RST_TARGET_VOLTAGE;
      cfg_q.curr_setpoint  <= RST_TARGET_CURRENT;
      cfg_q.cutoff_current <= RST_CUTOFF_CURRENT;
      cfg_q.min_voltage    <= RST_MIN_VOLTAGE;
      cfg_q.max_voltage    <= RST_MAX_VOLTAGE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/ccv_step.sv]
// Next-state logic of the CC/CV regulator for one word
// Depends on ccv_pkg
module ccv_step import ccv_pkg::*; (
  input  cfg_t             cfg_i,
  input  chg_state_t       state_i,
  input  logic             command_i,
  input  logic [MeasW-1:0] cell_voltage_i,
  input  logic [MeasW-1:0] cell_current_i,
  output chg_state_t       state_o
);

  logic [MeasW-1:0] tv, tc, cut, vmin, vmax;
  logic             in_cc, at_target, in_cv, fine_band, done_ok, low_cur;
  logic             cur_below, cur_above;
  logic [DriveW:0]  inc_sum;
  logic [DriveW-1:0] drive_inc, drive_dec1, drive_dec10, drive_start;

  // widen registers to the measurement width
  assign tv   = MeasW'(cfg_i.volt_setpoint);
  assign tc   = MeasW'(cfg_i.curr_setpoint);
  assign cut  = MeasW'(cfg_i.cutoff_current);
  assign vmin = MeasW'(cfg_i.min_voltage);
  assign vmax = MeasW'(cfg_i.max_voltage);

  // voltage window decode
  assign in_cc     = (cell_voltage_i > vmin) && (cell_voltage_i < tv);
  assign at_target = (cell_voltage_i == tv);
  assign in_cv     = (cell_voltage_i > tv) && (cell_voltage_i < vmax);
  assign fine_band = ({1'b0, cell_voltage_i} <= ({1'b0, tv} + CV_FINE_BAND));

  assign cur_below = (cell_current_i < tc);
  assign cur_above = (cell_current_i > tc);

  // end-of-charge: v > tv-3 and c < cut-1, rearranged to avoid negatives
  assign done_ok = (({1'b0, cell_voltage_i} + SUCCESS_MARGIN) > {1'b0, tv}) &&
                   (({1'b0, cell_current_i} + 17'd1) < {1'b0, cut});
  assign low_cur = (cell_current_i < MIN_CURRENT);

  // saturating drive steps
  assign inc_sum     = {1'b0, state_i.drive} + (DriveW+1)'(1);
  assign drive_inc   = inc_sum[DriveW] ? DRIVE_MAX : inc_sum[DriveW-1:0];
  assign drive_dec1  = (state_i.drive != '0) ? state_i.drive - DriveW'(1) : '0;
  assign drive_dec10 = (state_i.drive > CV_COARSE_STEP) ?
                       state_i.drive - CV_COARSE_STEP : '0;
  assign drive_start = {{(DriveW-RegW-1){1'b0}}, cfg_i.curr_setpoint, 1'b0};

  always_comb begin
    status_e mode;
    logic    fault;
    mode    = ST_IDLE;
    fault   = 1'b0;
    state_o = state_i;
    if (command_i == CMD_START) begin
      state_o.drive   = drive_start;
      state_o.running = 1'b1;
      state_o.outcome = ST_IDLE;
    end else if (state_i.running) begin
      // drive step by regulation mode
      priority if (in_cc) begin
        if (cur_below)      state_o.drive = drive_inc;
        else if (cur_above) state_o.drive = drive_dec1;
        mode = ST_CC;
      end else if (at_target) begin
        mode = ST_CV;
      end else if (in_cv) begin
        state_o.drive = fine_band ? drive_dec1 : drive_dec10;
        mode = ST_CV;
      end else begin
        fault = 1'b1;
        mode  = ST_VFAULT;
      end
      // run termination, voltage fault first
      priority if (fault) begin
        state_o.running = 1'b0;
        state_o.outcome = ST_VFAULT;
      end else if (done_ok) begin
        state_o.running = 1'b0;
        state_o.outcome = ST_SUCCESS;
      end else if (low_cur) begin
        state_o.running = 1'b0;
        state_o.outcome = ST_NOCUR;
      end else begin
        state_o.outcome = mode;
      end
    end
  end

endmodule

[hdl/cc_cv_charge_controller.sv]
// CC/CV charge controller top level: input stage, regulator state and result register
// Depends on ccv_pkg, ccv_cfg_regs, ccv_step and the assertion macros header
//
// One word in, one word out. An input word is taken into an input register,
// its regulator step is worked out in a single combinational pass and written
// to the state register, which is also the result register on the master side.
// A new word can be taken every clock cycle while the master side does not stall;
// the accepting edge loads the input register, and the state/result register is
// written when the word leaves the input register. A word leaves the input
// register when the result slot is empty or its result is taken in the same
// cycle, and the slave side is ready whenever the input register is empty or
// its word leaves. A start word (tuser 0) loads the drive value with twice the
// target current and enables charging; sample words (tuser 1) step the drive
// value and may end the run. The user must write configuration registers only
// while no word is in flight; the block itself does not enforce this.
`include "cc_cv_charge_controller_macros.svh"
module cc_cv_charge_controller import ccv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [RegW-1:0]     cfg_wdata_i,
  // slave side
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // cell_voltage[15:0], cell_current[31:16]
  input  logic [0:0]          s_axis_tuser,   // command[0]
  // master side
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata    // drive_value[15:0], charge_enable[16],
                                              // status[19:17], zero[23:20]
);

  cfg_t             cfg;
  chg_state_t       state_q, state_d;
  logic             in_valid_q;
  logic             cmd_q;
  logic [MeasW-1:0] volt_q, curr_q;
  logic             out_valid_q;
  logic             out_free, fire, in_take;

  ccv_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // handshake: result slot frees when empty or taken
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= s_axis_tuser[0];
      volt_q <= s_axis_tdata[15:0];
      curr_q <= s_axis_tdata[31:16];
    end
  end

  ccv_step u_step (
    .cfg_i          (cfg),
    .state_i        (state_q),
    .command_i      (cmd_q),
    .cell_voltage_i (volt_q),
    .cell_current_i (curr_q),
    .state_o        (state_d)
  );

  // regulator state, doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{drive: '0, running: 1'b0, outcome: ST_IDLE};
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= fire;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, state_q.outcome, state_q.running, state_q.drive};

  // checks
  `CCV_ASSERT_NEXT(a_start_loads, fire && (cmd_q == CMD_START),
                   state_q.running && (state_q.outcome == ST_IDLE))
  `CCV_ASSERT_NEXT(a_idle_sample_holds, fire && (cmd_q == CMD_SAMPLE) && !state_q.running,
                   $stable(state_q.drive) && !state_q.running)
  `CCV_ASSERT_IMPL(a_end_disables, state_q.outcome == ST_SUCCESS ||
                   state_q.outcome == ST_VFAULT || state_q.outcome == ST_NOCUR,
                   !state_q.running)
  `CCV_ASSERT_IMPL(a_run_status, state_q.running, state_q.outcome == ST_IDLE ||
                   state_q.outcome == ST_CC || state_q.outcome == ST_CV)
  `CCV_ASSERT_IMPL(a_ready_when_empty, !out_valid_q, s_axis_tready)

endmodule

[bench/cc_cv_charge_controller_test.sv]
// Testbench for the CC/CV charge controller: directed and random charge runs, predicted results
// checked word by word on the master side. Depends on ccv_pkg and cc_cv_charge_controller
`timescale 1ns / 100ps
module cc_cv_charge_controller_test;
  import ccv_pkg::*;

  localparam int RESULT_LATENCY = 1;
  localparam int RUN_LIMIT_NS   = 5_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [RegW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;   // cell_voltage[15:0], cell_current[31:16]
  logic [0:0]          s_axis_tuser;   // command[0]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [23:0]         m_axis_tdata;   // drive_value[15:0], charge_enable[16], status[19:17]

  // settings the block holds, and the regulator state that follows from them
  cfg_t       cfg_shadow;
  chg_state_t regulator;
  chg_state_t expected_reports[$];

  bit bursts_on = 1'b1;
  int hold_left = 0;
  int mismatches = 0;

  cc_cv_charge_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // one regulator step: updates the predicted state and returns the report word
  function automatic chg_state_t regulate(input logic cmd, input logic [15:0] volt,
                                          input logic [15:0] amps);
    int      vi, ci, tv, tc, co, vmin, vmax, step;
    status_e mode;
    bit      fault;
    vi   = int'(volt);
    ci   = int'(amps);
    tv   = int'(cfg_shadow.volt_setpoint);
    tc   = int'(cfg_shadow.curr_setpoint);
    co   = int'(cfg_shadow.cutoff_current);
    vmin = int'(cfg_shadow.min_voltage);
    vmax = int'(cfg_shadow.max_voltage);
    fault = 1'b0;
    mode  = ST_IDLE;
    if (cmd == CMD_START) begin
      regulator.drive   = 16'(tc * 2);
      regulator.running = 1'b1;
      regulator.outcome = ST_IDLE;
    end else if (regulator.running) begin
      if (vi > vmin && vi < tv) begin
        // constant current: one step toward the target current
        if (ci < tc && regulator.drive != DRIVE_MAX)
          regulator.drive = 16'(int'(regulator.drive) + 1);
        else if (ci > tc && regulator.drive != 0)
          regulator.drive = 16'(int'(regulator.drive) - 1);
        mode = ST_CC;
      end else if (vi == tv) begin
        mode = ST_CV;
      end else if (vi > tv && vi < vmax) begin
        // constant voltage: coarse step away from the target, fine step near it
        step = (vi > tv + 5) ? 10 : 1;
        regulator.drive = (int'(regulator.drive) > step) ?
                          16'(int'(regulator.drive) - step) : 16'd0;
        mode = ST_CV;
      end else begin
        fault = 1'b1;
      end
      if (fault) begin
        regulator.running = 1'b0;
        regulator.outcome = ST_VFAULT;
      end else if (vi > tv - 3 && ci < co - 1) begin
        regulator.running = 1'b0;
        regulator.outcome = ST_SUCCESS;
      end else if (ci < 10) begin
        regulator.running = 1'b0;
        regulator.outcome = ST_NOCUR;
      end else begin
        regulator.outcome = mode;
      end
    end
    return regulator;
  endfunction

  // uniform value between two bounds, clipped to the measurement range
  function automatic logic [15:0] span(input int lo, input int hi);
    int a, b;
    a = (lo < 0) ? 0 : ((lo > 65535) ? 65535 : lo);
    b = (hi < 0) ? 0 : ((hi > 65535) ? 65535 : hi);
    return 16'($urandom_range(b, a));
  endfunction

  function automatic cfg_t draw_settings();
    cfg_t s;
    s.min_voltage    = 13'($urandom_range(0, 3000));
    s.volt_setpoint  = 13'($urandom_range(int'(s.min_voltage) + 1, 4900));
    s.max_voltage    = 13'($urandom_range(int'(s.volt_setpoint) + 1, 5000));
    s.curr_setpoint  = 13'($urandom_range(0, 5000));
    s.cutoff_current = 13'($urandom_range(0, 400));
    return s;
  endfunction

  // offer one word, with an optional gap first, and predict its result on acceptance
  task automatic send_word(input logic cmd, input logic [15:0] volt, input logic [15:0] amps);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {amps, volt};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_reports.push_back(regulate(cmd, volt, amps));
  endtask

  // stop offering and let every result drain out of the pipeline
  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic apply_settings(input cfg_t s);
    wait_until_idle();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= CFG_TARGET_VOLTAGE;
    cfg_wdata_i <= s.volt_setpoint;
    @(posedge clk_i);
    cfg_addr_i <= CFG_TARGET_CURRENT;
    cfg_wdata_i <= s.curr_setpoint;
    @(posedge clk_i);
    cfg_addr_i <= CFG_CUTOFF_CURRENT;
    cfg_wdata_i <= s.cutoff_current;
    @(posedge clk_i);
    cfg_addr_i <= CFG_MIN_VOLTAGE;
    cfg_wdata_i <= s.min_voltage;
    @(posedge clk_i);
    cfg_addr_i <= CFG_MAX_VOLTAGE;
    cfg_wdata_i <= s.max_voltage;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cfg_shadow = s;
  endtask

  // sample aimed at one region of the charge curve under the current settings
  task automatic pick_sample(output logic [15:0] volt, output logic [15:0] amps);
    int tv, tc, co, vmin, vmax, kind;
    tv   = int'(cfg_shadow.volt_setpoint);
    tc   = int'(cfg_shadow.curr_setpoint);
    co   = int'(cfg_shadow.cutoff_current);
    vmin = int'(cfg_shadow.min_voltage);
    vmax = int'(cfg_shadow.max_voltage);
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      volt = span(vmin + 1, tv - 1);
      amps = span(tc - 15, tc + 15);
    end else if (kind < 70) begin
      case ($urandom_range(0, 2))
        0:       volt = 16'(tv);
        1:       volt = span(tv + 1, tv + 5);
        default: volt = span(tv + 6, vmax - 1);
      endcase
      amps = span(co + 10, tc + 100);
    end else if (kind < 78) begin
      volt = span(tv - 2, vmax - 1);
      amps = span(0, co - 2);
    end else if (kind < 84) begin
      volt = span(vmin + 1, vmax - 1);
      amps = span(0, 9);
    end else if (kind < 90) begin
      volt = $urandom_range(0, 1) ? span(0, vmin) : span(vmax, 65535);
      amps = span(co + 10, tc + 100);
    end else begin
      volt = 16'($urandom);
      amps = 16'($urandom);
    end
  endtask

  // charge runs: starts, shaped samples, restarts and a little noise
  task automatic run_charge_cycles(input int count);
    logic [15:0] volt, amps;
    int          r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_word(1'($urandom), 16'($urandom), 16'($urandom));
      end else if (!regulator.running || r < 9) begin
        send_word(CMD_START, 16'($urandom), 16'($urandom));
      end else begin
        pick_sample(volt, amps);
        send_word(CMD_SAMPLE, volt, amps);
      end
    end
  endtask

  // reset settings, every mode and every way a run can end
  task automatic test_reset_defaults();
    send_word(CMD_SAMPLE, 16'd4000, 16'd500);     // no run yet: held idle state
    send_word(CMD_START, 16'hFFFF, 16'hFFFF);
    send_word(CMD_START, 16'h0000, 16'h0000);     // restart while running
    send_word(CMD_SAMPLE, 16'd4000, 16'd500);     // cc step up
    send_word(CMD_SAMPLE, 16'd4000, 16'd1500);    // cc step down
    send_word(CMD_SAMPLE, 16'd4000, 16'd1000);    // current on target
    send_word(CMD_SAMPLE, 16'd4200, 16'd500);     // voltage on target
    send_word(CMD_SAMPLE, 16'd4205, 16'd500);     // fine cv step
    send_word(CMD_SAMPLE, 16'd4206, 16'd500);     // coarse cv step
    send_word(CMD_SAMPLE, 16'd4349, 16'hFFFF);    // top of the window
    send_word(CMD_SAMPLE, 16'hFFFF, 16'hFFFF);    // over-voltage
    send_word(CMD_SAMPLE, 16'd4000, 16'd500);     // run over: held
    send_word(CMD_START, 16'($urandom), 16'($urandom));
    send_word(CMD_SAMPLE, 16'd0, 16'd0);          // voltage fault wins over current
    send_word(CMD_START, 16'($urandom), 16'($urandom));
    send_word(CMD_SAMPLE, 16'd1000, 16'd500);     // on the lower bound
    send_word(CMD_START, 16'($urandom), 16'($urandom));
    send_word(CMD_SAMPLE, 16'd4350, 16'd500);     // on the upper bound
    send_word(CMD_START, 16'($urandom), 16'($urandom));
    send_word(CMD_SAMPLE, 16'd1001, 16'd5);       // no current
    send_word(CMD_START, 16'($urandom), 16'($urandom));
    send_word(CMD_SAMPLE, 16'd4198, 16'd48);      // success just inside both margins
    send_word(CMD_START, 16'($urandom), 16'($urandom));
    send_word(CMD_SAMPLE, 16'd4200, 16'd0);       // success on target
  endtask

  // drive floor, target outside the window and negative thresholds
  task automatic test_floor_and_window();
    wait_until_idle();
    // unused register indexes must leave the settings alone
    cfg_we_i <= 1'b1;
    for (int a = CFG_MAX_VOLTAGE + 1; a < (1 << CfgAddrW); a++) begin
      cfg_addr_i  <= a[CfgAddrW-1:0];
      cfg_wdata_i <= 13'($urandom);
      @(posedge clk_i);
    end
    apply_settings('{volt_setpoint: 13'd500, curr_setpoint: 13'd0, cutoff_current: 13'd0,
                     min_voltage: 13'd1000, max_voltage: 13'd4350});
    send_word(CMD_START, 16'($urandom), 16'($urandom));
    send_word(CMD_SAMPLE, 16'd500, 16'd100);      // on target below the window
    send_word(CMD_SAMPLE, 16'd600, 16'd100);      // coarse step at zero
    send_word(CMD_SAMPLE, 16'd502, 16'd100);      // fine step at zero
    send_word(CMD_SAMPLE, 16'd2000, 16'd100);     // above target
    apply_settings('{volt_setpoint: 13'd1, curr_setpoint: 13'd5000, cutoff_current: 13'd0,
                     min_voltage: 13'd0, max_voltage: 13'd8});
    send_word(CMD_START, 16'($urandom), 16'($urandom));
    send_word(CMD_SAMPLE, 16'd4, 16'd20);
    send_word(CMD_SAMPLE, 16'd1, 16'd0);          // thresholds below zero
    send_word(CMD_START, 16'($urandom), 16'($urandom));
    send_word(CMD_SAMPLE, 16'd0, 16'd20);         // at the lower bound of zero
  endtask

  // several register settings, the extremes among them
  task automatic test_register_sweep();
    cfg_t s;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: s = '{RST_TARGET_VOLTAGE, RST_TARGET_CURRENT, RST_CUTOFF_CURRENT,
                 RST_MIN_VOLTAGE, RST_MAX_VOLTAGE};
        1: s = '0;
        2: s = '{13'd5000, 13'd5000, 13'd5000, 13'd5000, 13'd5000};
        3: s = '{volt_setpoint: 13'd2, curr_setpoint: 13'd3, cutoff_current: 13'd0,
                 min_voltage: 13'd0, max_voltage: 13'd9};
        default: s = draw_settings();
      endcase
      apply_settings(s);
      run_charge_cycles(200);
    end
  endtask

  // long receiver hold-off while words keep coming, so the input stalls
  task automatic test_output_backpressure();
    apply_settings(draw_settings());
    bursts_on = 1'b0;
    hold_left = 300;
    run_charge_cycles(60);
    bursts_on = 1'b1;
  endtask

  // closing stretch at full rate on both sides
  task automatic test_steady_stream();
    apply_settings(draw_settings());
    bursts_on = 1'b0;
    run_charge_cycles(350);
  endtask

  // receiver: random stalls, plus the long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    chg_state_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        $error("result word %h with none expected", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (m_axis_tdata[15:0] !== want.drive) begin
          $error("drive_value: expected %0d, got %0d", want.drive, m_axis_tdata[15:0]);
          mismatches++;
        end
        if (m_axis_tdata[16] !== want.running) begin
          $error("charge_enable: expected %0d, got %0d", want.running, m_axis_tdata[16]);
          mismatches++;
        end
        if (m_axis_tdata[19:17] !== want.outcome) begin
          $error("status: expected %0d, got %0d", want.outcome, m_axis_tdata[19:17]);
          mismatches++;
        end
      end
    end
  end

  // test sequence
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_shadow = '{RST_TARGET_VOLTAGE, RST_TARGET_CURRENT, RST_CUTOFF_CURRENT,
                   RST_MIN_VOLTAGE, RST_MAX_VOLTAGE};
    regulator  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_floor_and_window();
    test_register_sweep();
    test_output_backpressure();
    test_steady_stream();

    wait_until_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/ccv_pkg.sv
hdl/ccv_cfg_regs.sv
hdl/ccv_step.sv
hdl/cc_cv_charge_controller.sv
bench/cc_cv_charge_controller_test.sv
